>>> design/utf7_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and character functions for the UTF-7 style encoder.
// No dependencies; used by utf7_step and utf7_base64_encoder.
package utf7_pkg;

    // Most characters one text byte can produce: flush of three, '-', the byte
    localparam int MAX_CHARS = 5;
    localparam int CNT_W     = $clog2(MAX_CHARS + 1);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    // Characters produced by one request, in send order
    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [CNT_W-1:0]          cnt;
        logic                      is_last;
    } t_char_list;

    // Map a 6-bit value onto the base64 alphabet A-Z a-z 0-9 + /
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] r;
        r = 8'h2F;
        if (v < 6'd26) begin
            r = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            r = 8'h61 + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            r = 8'h30 + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            r = CH_PLUS;
        end
        return r;
    endfunction

    // Bytes that pass through without entering a base64 run
    function automatic logic is_direct(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h30 && c <= 8'h39) || c == 8'h27 || c == 8'h28 ||
               c == 8'h29 || c == 8'h2C || c == 8'h2D || c == 8'h2E ||
               c == 8'h2F || c == 8'h3A || c == 8'h3F;
    endfunction

endpackage

>>> design/utf7_base64_encoder.sv
`timescale 1ns / 1ps
// Top level of the UTF-7 style encoder: input handshake, character buffer, output register.
// Depends on utf7_pkg and utf7_step.
//
// Each accepted byte yields zero to five ASCII characters, sent one per cycle
// while the output is not stalled. A byte that yields n characters (n >= 1)
// holds the input side until the buffer has moved all n to the output register;
// the next byte is taken in the cycle the buffer hands over its last character,
// so one-character bytes stream at one per cycle while the output does not stall.
// A byte that yields no character does not load the buffer. The output register
// lets a new byte enter while a finished character still waits on a stalled output.
module utf7_base64_encoder
    import utf7_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_is_final,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_char,
    output logic       o_run_last,
    output logic       o_text_done
);

    t_char_list                 w_list;
    logic                       w_in_acc;
    logic                       w_move;
    logic                       w_last_move;

    logic                       r_buf_valid;
    logic [MAX_CHARS-1:0][7:0]  r_buf_chars;
    logic [CNT_W-1:0]           r_buf_cnt;
    logic [CNT_W-1:0]           r_buf_idx;
    logic                       r_buf_final;

    logic                       r_out_valid;
    logic [7:0]                 r_out_char;
    logic                       r_out_last;
    logic                       r_out_done;

    utf7_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_in_acc),
        .i_byte   (i_in_byte),
        .i_final  (i_is_final),
        .o_list   (w_list)
    );

    // Move one character from buffer to output register when there is room
    assign w_move      = r_buf_valid && (!r_out_valid || !i_out_stall);
    assign w_last_move = w_move && (r_buf_idx == r_buf_cnt - 1'b1);
    assign o_in_stall  = r_buf_valid && !w_last_move;
    assign w_in_acc    = i_in_valid && !o_in_stall;

    // Load a new request's characters, or step through the held ones
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_valid <= 1'b0;
            r_buf_idx   <= '0;
        end else if (w_in_acc && w_list.cnt != '0) begin
            r_buf_valid <= 1'b1;
            r_buf_idx   <= '0;
        end else if (w_last_move) begin
            r_buf_valid <= 1'b0;
        end else if (w_move) begin
            r_buf_idx   <= r_buf_idx + 1'b1;
        end
    end

    // Buffer payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_buf_chars <= w_list.chars;
            r_buf_cnt   <= w_list.cnt;
            r_buf_final <= w_list.is_last;
        end
    end

    // Output register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_char <= r_buf_chars[r_buf_idx];
            r_out_last <= w_last_move;
            r_out_done <= w_last_move && r_buf_final;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_run_last  = r_out_last;
    assign o_text_done = r_out_done;

    // Buffer index stays inside the loaded character count
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buf_valid |-> (r_buf_cnt != '0 && r_buf_idx < r_buf_cnt))
        else $error("character buffer index out of range");

    // A loaded buffer is never overwritten before its last character moves
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |-> (!r_buf_valid || w_last_move))
        else $error("request accepted over a busy buffer");

    // End of text only marks the last character of a request
    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_text_done |-> o_run_last)
        else $error("text end flag without request end flag");

    // A waiting character is not replaced while the output is stalled
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out_char))
        else $error("stalled output character changed");

endmodule

>>> design/utf7_step.sv
`timescale 1ns / 1ps
// Run state of the encoder and the per-byte character list builder.
// Depends on utf7_pkg.
module utf7_step
    import utf7_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_final,
    output t_char_list o_list
);

    logic        r_in_shift;
    logic [1:0]  r_group_count;
    logic [15:0] r_held_bytes;
    logic        n_in_shift;
    logic [1:0]  n_group_count;
    logic [15:0] n_held_bytes;

    // Build the characters for this byte and the next run state
    always_comb begin
        t_char_list       lst;
        logic [CNT_W-1:0] k;
        logic [1:0]       gc;
        logic [15:0]      hb;
        logic [7:0]       b0;
        logic [7:0]       b1;
        lst           = '0;
        k             = '0;
        n_in_shift    = r_in_shift;
        n_group_count = r_group_count;
        n_held_bytes  = r_held_bytes;
        gc            = r_group_count;
        hb            = r_held_bytes;
        b0            = '0;
        b1            = '0;

        if (is_direct(i_byte)) begin
            if (r_in_shift) begin
                // Flush the partial group, then close the run
                b0 = hb[15:8];
                b1 = hb[7:0];
                if (gc != 2'd0) begin
                    lst.chars[k] = b64_char(b0[7:2]);
                    k = k + 1'b1;
                    if (gc == 2'd1) begin
                        lst.chars[k] = b64_char({b0[1:0], 4'b0000});
                        k = k + 1'b1;
                    end else begin
                        lst.chars[k] = b64_char({b0[1:0], b1[7:4]});
                        k = k + 1'b1;
                        lst.chars[k] = b64_char({b1[3:0], 2'b00});
                        k = k + 1'b1;
                    end
                end
                lst.chars[k] = CH_MINUS;
                k = k + 1'b1;
            end
            lst.chars[k] = i_byte;
            k = k + 1'b1;
            n_in_shift    = 1'b0;
            n_group_count = 2'd0;
            n_held_bytes  = '0;
        end else begin
            // Open a run if none is open
            if (!r_in_shift) begin
                lst.chars[k] = CH_PLUS;
                k  = k + 1'b1;
                gc = 2'd0;
                hb = '0;
            end
            n_in_shift = 1'b1;
            b0 = hb[15:8];
            b1 = hb[7:0];
            unique case (gc)
                2'd0: begin
                    n_group_count = 2'd1;
                    n_held_bytes  = {i_byte, 8'h00};
                end
                2'd1: begin
                    n_group_count = 2'd2;
                    n_held_bytes  = {hb[15:8], i_byte};
                end
                default: begin
                    // Complete group: four characters
                    lst.chars[k] = b64_char(b0[7:2]);
                    k = k + 1'b1;
                    lst.chars[k] = b64_char({b0[1:0], b1[7:4]});
                    k = k + 1'b1;
                    lst.chars[k] = b64_char({b1[3:0], i_byte[7:6]});
                    k = k + 1'b1;
                    lst.chars[k] = b64_char(i_byte[5:0]);
                    k = k + 1'b1;
                    n_group_count = 2'd0;
                    n_held_bytes  = '0;
                end
            endcase
            // Last byte of the text: flush without '-'
            if (i_final && n_group_count != 2'd0) begin
                b0 = n_held_bytes[15:8];
                b1 = n_held_bytes[7:0];
                lst.chars[k] = b64_char(b0[7:2]);
                k = k + 1'b1;
                if (n_group_count == 2'd1) begin
                    lst.chars[k] = b64_char({b0[1:0], 4'b0000});
                    k = k + 1'b1;
                end else begin
                    lst.chars[k] = b64_char({b0[1:0], b1[7:4]});
                    k = k + 1'b1;
                    lst.chars[k] = b64_char({b1[3:0], 2'b00});
                    k = k + 1'b1;
                end
            end
        end

        if (i_final) begin
            n_in_shift    = 1'b0;
            n_group_count = 2'd0;
            n_held_bytes  = '0;
        end
        lst.cnt     = k;
        lst.is_last = i_final;
        o_list      = lst;
    end

    // Advance the run state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_shift    <= 1'b0;
            r_group_count <= 2'd0;
            r_held_bytes  <= '0;
        end else if (i_accept) begin
            r_in_shift    <= n_in_shift;
            r_group_count <= n_group_count;
            r_held_bytes  <= n_held_bytes;
        end
    end

endmodule
